// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int REQ_TYPE_W   = 2;
   localparam int WORD_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int OCCUPANCY_W  = 5;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_REAR  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_REAR   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic [REQ_TYPE_W-1:0]    req_code_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [STATUS_W-1:0]      status_code_type;
   typedef logic [OCCUPANCY_W-1:0]   occupancy_type;

endpackage

// ===== hw/rtl/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels carrying deque requests and their results.
// ----------------------------------------------------------------------------
interface deq_req_if;
   import deq_pkg::*;

   logic         valid;
   logic         ready;
   req_code_type req_type;
   word_type     push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic            valid;
   logic            ready;
   word_type        pop_value;
   status_code_type status;
   occupancy_type   occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface

// ===== hw/rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: takes one request, then holds the result beat.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic rsp_ready,
   output logic req_ready,
   output logic rsp_valid,
   output logic take
);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_SEND = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign take      = req_valid && req_ready;

   a_take_then_send: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("result beat not raised after request");

   a_send_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(take))
      else $error("result beat without request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !take)
      else $error("request taken while result pending");
endmodule

// ===== hw/rtl/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Head, tail and count registers around the circular word store.
// ----------------------------------------------------------------------------
module deq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  deq_pkg::req_code_type    req_type,
   input  deq_pkg::word_type        push_value,
   output deq_pkg::word_type        pop_value,
   output deq_pkg::status_code_type status,
   output deq_pkg::occupancy_type   occupancy
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_code_type  status_ff, status_in;
   logic             pop_ok_ff, pop_ok_in;

   logic             full, empty;
   logic [IDX_W-1:0] head_prev, head_next, tail_prev, tail_next;
   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // wrap explicitly so any depth works, not only powers of two
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = head_prev;
      ram_raddr = head_ff;
      if (take) begin
         status_in = ST_DONE;
         pop_ok_in = 1'b0;
         unique case (req_type)
            REQ_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in   = head_prev;
                  ram_we    = 1'b1;
                  ram_waddr = head_prev;
                  count_in  = count_ff + 1'b1;
               end
            end
            REQ_PUSH_REAR: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  tail_in   = tail_next;
                  ram_we    = 1'b1;
                  ram_waddr = tail_ff;
                  count_in  = count_ff + 1'b1;
               end
            end
            REQ_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  head_in   = head_next;
                  ram_re    = 1'b1;
                  ram_raddr = head_ff;
                  pop_ok_in = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            REQ_POP_REAR: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  tail_in   = tail_prev;
                  ram_re    = 1'b1;
                  ram_raddr = tail_prev;
                  pop_ok_in = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: status_in = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         pop_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         pop_ok_ff <= pop_ok_in;
      end
      status_ff <= status_in;
   end

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (push_value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // read data stays in the ram output register until the next pop
   assign pop_value = pop_ok_ff ? word_type'(ram_rdata) : '0;
   assign status    = status_ff;
   assign occupancy = OCCUPANCY_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("count beyond depth");

   a_full_push_frozen: assert property (@(posedge clock) disable iff (reset)
      take && full && !req_type[1] |=> $stable(count_ff) && status_ff == ST_FULL)
      else $error("push into full deque changed state");

   a_empty_pop_frozen: assert property (@(posedge clock) disable iff (reset)
      take && empty && req_type[1] |=> $stable(count_ff) && !pop_ok_ff)
      else $error("pop from empty deque changed state");
endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per beat: req_type selects push front, push
//   rear, pop front or pop rear; push_value is used by pushes only.
//   rsp_ch returns exactly one beat per request with pop_value (the removed
//   word, zero unless a pop succeeded), status (done, empty on pop, full on
//   push) and occupancy (words held after the request, low five bits).
//   A push into a full deque or a pop from an empty one changes nothing.
// Timing:
//   a request is taken while the block is idle; its result is valid on the
//   next cycle, read straight from the store's registered read port. The
//   next request is taken in the cycle after the result beat, so a new request
//   is never taken while a result is still pending.
// Reset and stalls:
//   reset empties the deque (head, tail and count to zero); store contents
//   are not cleared. While rsp_ch.ready is low the result beat is held and
//   req_ch.ready stays low.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);
   import deq_pkg::*;

   logic take;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .take      (take)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_type   (req_ch.req_type),
      .push_value (req_ch.push_value),
      .pop_value  (rsp_ch.pop_value),
      .status     (rsp_ch.status),
      .occupancy  (rsp_ch.occupancy)
   );
endmodule

// ===== test/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. Requests go in through the
// request channel. A shadow deque in the bench tracks every accepted beat
// and queues the result it expects. Each result beat is compared field by
// field with the oldest one queued. Traffic is a short directed run over
// empty, full and the word extremes, then random runs with biased push/pop
// mixes, a long receiver hold-off, a drain pause and a final run with no
// idling.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int DEPTH = 16;

   typedef struct {
      word_type        pop_value;
      status_code_type status;
      occupancy_type   occupancy;
   } result_beat_type;

   logic clock;
   logic reset;

   deq_req_if req_ch();
   deq_rsp_if rsp_ch();

   double_ended_queue #(
      .DEPTH (DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow deque
   word_type deque_words [DEPTH];
   int       front_idx;
   int       rear_idx;
   int       words_held;

   result_beat_type pending_results [$];
   int              error_count;
   bit              idling_on;
   int              hold_cycles_req;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver side: random stalls, plus a long hold-off when one is requested
   initial begin : rsp_ready_driver
      int stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req > 0) begin
            stall = hold_cycles_req;
            hold_cycles_req = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic result_beat_type apply_request(req_code_type code, word_type value);
      result_beat_type r;
      r.pop_value = '0;
      r.status    = ST_DONE;
      case (code)
         REQ_PUSH_FRONT: begin
            if (words_held >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
               deque_words[front_idx] = value;
               words_held++;
            end
         end
         REQ_PUSH_REAR: begin
            if (words_held >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               deque_words[rear_idx] = value;
               rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
               words_held++;
            end
         end
         REQ_POP_FRONT: begin
            if (words_held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.pop_value = deque_words[front_idx];
               front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
               words_held--;
            end
         end
         default: begin
            if (words_held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
               r.pop_value = deque_words[rear_idx];
               words_held--;
            end
         end
      endcase
      r.occupancy = occupancy_type'(words_held);
      return r;
   endfunction

   function automatic void check_result();
      result_beat_type exp;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result beat, actual pop_value %0d status %0d occupancy %0d",
                  $time, rsp_ch.pop_value, rsp_ch.status, rsp_ch.occupancy);
         error_count++;
         return;
      end
      exp = pending_results.pop_front();
      if (rsp_ch.pop_value !== exp.pop_value) begin
         $display("%0t: pop_value mismatch, expected %0d, actual %0d",
                  $time, exp.pop_value, rsp_ch.pop_value);
         error_count++;
      end
      if (rsp_ch.status !== exp.status) begin
         $display("%0t: status mismatch, expected %0d, actual %0d",
                  $time, exp.status, rsp_ch.status);
         error_count++;
      end
      if (rsp_ch.occupancy !== exp.occupancy) begin
         $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                  $time, exp.occupancy, rsp_ch.occupancy);
         error_count++;
      end
   endfunction

   // request beats are predicted before result beats of the same edge are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(apply_request(req_ch.req_type, req_ch.push_value));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
         end
      end
   end

   // valid stays high after the beat; an idle gap in the next call or a drain lowers it
   task automatic send_request(input req_code_type code, input word_type value);
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= code;
      req_ch.push_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_results_drained();
      int waited;
      req_ch.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_results.size() != 0 && waited < 5000);
   endtask

   function automatic req_code_type pick_request(int push_pct);
      if ($urandom_range(0, 99) < push_pct) begin
         return ($urandom_range(0, 1) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
      end
      return ($urandom_range(0, 1) == 0) ? REQ_POP_FRONT : REQ_POP_REAR;
   endfunction

   function automatic word_type random_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic test_empty_and_full();
      word_type extreme_words [4];
      int       i;
      extreme_words[0] = 32'sh7FFF_FFFF;
      extreme_words[1] = 32'sh8000_0000;
      extreme_words[2] = '0;
      extreme_words[3] = '1;
      send_request(REQ_POP_FRONT, random_word());
      send_request(REQ_POP_REAR, random_word());
      // alternate ends so the front index wraps below zero
      for (i = 0; i < DEPTH; i++) begin
         send_request(i[0] ? REQ_PUSH_REAR : REQ_PUSH_FRONT,
                      (i < 4) ? extreme_words[i] : random_word());
      end
      send_request(REQ_PUSH_FRONT, 32'sh1234_5678);
      send_request(REQ_PUSH_REAR, 32'sh8765_4321);
      send_request(REQ_POP_FRONT, '0);
      send_request(REQ_POP_REAR, '0);
   endtask

   task automatic test_random_traffic(input int n_items, input bit with_idling);
      int sent;
      int burst;
      int push_pct;
      int i;
      sent = 0;
      while (sent < n_items) begin
         // biased bursts walk the occupancy between empty and full
         burst     = $urandom_range(20, 60);
         push_pct  = $urandom_range(10, 90);
         idling_on = with_idling && ($urandom_range(0, 3) != 0);
         for (i = 0; i < burst && sent < n_items; i++) begin
            send_request(pick_request(push_pct), random_word());
            sent++;
         end
      end
   endtask

   task automatic test_receiver_hold();
      int i;
      idling_on = 1'b1;
      hold_cycles_req = 300;
      for (i = 0; i < 40; i++) begin
         send_request(pick_request(70), random_word());
      end
   endtask

   task automatic test_drain_pause();
      int i;
      idling_on = 1'b1;
      for (i = 0; i < 30; i++) begin
         send_request(pick_request(60), random_word());
      end
      wait_results_drained();
      for (i = 0; i < 30; i++) begin
         send_request(pick_request(40), random_word());
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_PUSH_FRONT;
      req_ch.push_value <= '0;
      idling_on       = 1'b0;
      hold_cycles_req = 0;
      error_count     = 0;
      front_idx       = 0;
      rear_idx        = 0;
      words_held      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_full();
      test_random_traffic(1200, 1'b1);
      test_receiver_hold();
      test_drain_pause();
      test_random_traffic(350, 1'b0);

      wait_results_drained();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected result beats never arrived",
                  $time, pending_results.size());
         error_count += pending_results.size();
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
